// ===== sv/tcvr_pkg.sv =====
`timescale 1ns / 1ps
package tcvr_pkg;

  localparam int DATA_W   = 8;
  localparam int ADDR_W   = 16;
  localparam int OP_W     = 2;
  localparam int ROW_W    = 5;
  localparam int COL_W    = 7;
  localparam int LINE_W   = 4;
  localparam int SLINE_W  = 9;
  localparam int CHAR_W   = 7;
  localparam int GLYPH_AW = 11;
  localparam int GIDX_W   = 10;
  localparam int LOFF_W   = 12;
  localparam int CFG_IDX_W = 2;

  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = LOFF_W + RECIP_W;

  localparam int QDEPTH = 2;

  localparam logic [DATA_W-1:0] BASE_RESET    = 8'hF8;
  localparam logic [DATA_W-1:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 7'h20;
  localparam int                GLYPH_LINES   = 8;
  localparam logic [LINE_W-1:0] CURSOR_LINE_A = 4'd10;
  localparam logic [LINE_W-1:0] CURSOR_LINE_B = 4'd11;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_BASE_HIGH = 2'd0,
    CFG_ALTERNATE_FONT   = 2'd1,
    CFG_CONSOLE_MODE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    K_READ,
    K_RENDER,
    K_LOAD
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [DATA_W-1:0]    data;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic [GLYPH_AW-1:0]  gaddr;
  } qent_t;

  typedef enum logic [2:0] {
    F_CLEAR,
    F_IDLE,
    F_DIV,
    F_PUSH
  } fstate_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } bstate_t;

endpackage

// ===== sv/tcvr_queue.sv =====
`timescale 1ns / 1ps
module tcvr_queue import tcvr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_ent,
  output logic  full,
  input  logic  pop,
  output qent_t head,
  output logic  empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  qent_t            ent_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

// ===== sv/tcvr_front.sv =====
`timescale 1ns / 1ps
module tcvr_front import tcvr_pkg::*; #(
  parameter int WINDOW_BYTES = 2048,
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [DATA_W-1:0] in_write_data,
  input  logic [DATA_W-1:0] base_high,
  output logic              push,
  output qent_t             push_ent,
  input  logic              q_full
);

  localparam int AW      = $clog2(WINDOW_BYTES);
  localparam int VISIBLE = TEXT_COLUMNS * TEXT_ROWS;
  localparam longint RECIP = ((64'd1 << DIV_SHIFT) + TEXT_COLUMNS - 1) / TEXT_COLUMNS;
  localparam logic [AW-1:0] CLR_LAST = AW'(WINDOW_BYTES - 1);

  fstate_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [DATA_W-1:0] vram [WINDOW_BYTES];
  logic [DATA_W-1:0] rdata_r;

  kind_t             kind_r;
  logic [DATA_W-1:0] data_r;
  logic [LOFF_W-1:0] lo_r;
  logic              win_r;
  logic [ROW_W-1:0]  quot_r;

  logic [ADDR_W-1:0] offset;
  logic              in_win, in_vis, accept, clearing;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [PROD_W-1:0] prod;
  logic [LOFF_W-1:0] col_full;
  kind_t             kind_in;

  assign offset = in_address - {base_high, 8'h00};
  assign in_win = (offset < ADDR_W'(WINDOW_BYTES));
  assign in_vis = (offset < ADDR_W'(VISIBLE));
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_READ:  state_nxt = F_PUSH;
            OP_WRITE: state_nxt = (in_win && in_vis) ? F_DIV : F_IDLE;
            OP_LOAD:  state_nxt = F_PUSH;
            default:  state_nxt = F_IDLE;
          endcase
        end
      end
      F_DIV:   state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == F_IDLE);
    clearing  = (state_r == F_CLEAR);
    push      = (state_r == F_PUSH) && !q_full;
    clr_nxt   = clearing ? clr_r + 1'b1 : clr_r;
    mem_we    = clearing || (accept && in_opcode == OP_WRITE && in_win);
    mem_waddr = clearing ? clr_r : offset[AW-1:0];
    mem_wdata = clearing ? BYTE_ALL_ONES : in_write_data;
  end

  always_comb begin
    case (in_opcode)
      OP_WRITE: kind_in = K_RENDER;
      OP_LOAD:  kind_in = K_LOAD;
      default:  kind_in = K_READ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r <= vram[offset[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_in;
      data_r <= in_write_data;
      win_r  <= in_win;
      lo_r   <= (in_opcode == OP_LOAD) ? LOFF_W'(in_address[GLYPH_AW-1:0])
                                       : offset[LOFF_W-1:0];
    end
  end

  // Row comes from a multiply by the reciprocal of the column count, exact for all
  // visible offsets.
  assign prod = PROD_W'(lo_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (state_r == F_DIV) begin
      quot_r <= prod[DIV_SHIFT +: ROW_W];
    end
  end

  assign col_full = lo_r - LOFF_W'(LOFF_W'(quot_r) * LOFF_W'(TEXT_COLUMNS));

  always_comb begin
    push_ent.kind  = kind_r;
    push_ent.data  = (kind_r == K_READ) ? (win_r ? rdata_r : BYTE_ALL_ONES) : data_r;
    push_ent.row   = quot_r;
    push_ent.col   = col_full[COL_W-1:0];
    push_ent.gaddr = lo_r[GLYPH_AW-1:0];
  end

endmodule

// ===== sv/tcvr_back.sv =====
`timescale 1ns / 1ps
module tcvr_back import tcvr_pkg::*; #(
  parameter int CELL_LINES     = 12,
  parameter int FONT_SET_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  qent_t              q_head,
  output logic               q_pop,
  input  logic               alt_font,
  input  logic               console_mode,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DATA_W-1:0]  out_read_data,
  output logic               out_is_render,
  output logic [DATA_W-1:0]  out_pixel_bits,
  output logic [SLINE_W-1:0] out_screen_line,
  output logic [COL_W-1:0]   out_cell_column,
  output logic               out_text_valid,
  output logic [CHAR_W-1:0]  out_text_char,
  output logic               out_last
);

  localparam int GLYPH_DEPTH = 1 << GLYPH_AW;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(CELL_LINES - 1);

  bstate_t state_r, state_nxt;
  qent_t   cur_r, cur_nxt;
  logic [LINE_W-1:0]  line_r, line_nxt;
  logic [SLINE_W-1:0] base_r;

  logic [DATA_W-1:0] gmem [GLYPH_DEPTH];
  logic [DATA_W-1:0] gdata_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] read_data_r, pixel_r;
  logic              is_render_r, text_valid_r, last_r;
  logic [SLINE_W-1:0] sline_r;
  logic [COL_W-1:0]  col_r;
  logic [CHAR_W-1:0] char_r;

  logic                out_free, load_read, load_line;
  logic [CHAR_W-1:0]   code_nxt, code, ch;
  logic [GIDX_W-1:0]   gidx_rd, gidx;
  logic [GLYPH_AW-1:0] gaddr_rd;
  logic                blank, cursor_line;
  logic [DATA_W-1:0]   px;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && q_head.kind == K_RENDER) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (out_free && line_r == LAST_LINE) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state_r == B_IDLE) && !q_empty && (q_head.kind != K_READ || out_free);
    load_read = q_pop && q_head.kind == K_READ;
    load_line = (state_r == B_RUN) && out_free;
    cur_nxt   = q_pop ? q_head : cur_r;
    if (q_pop) begin
      line_nxt = '0;
    end else if (load_line) begin
      line_nxt = line_r + 1'b1;
    end else begin
      line_nxt = line_r;
    end
  end

  // The glyph read is addressed with the next line so that its data lines up with line_r.
  assign code_nxt = cur_nxt.data[CHAR_W-1:0];
  assign gidx_rd  = {code_nxt - CHAR_SPACE, line_nxt[2:0]};
  assign gaddr_rd = {alt_font, gidx_rd};

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == K_LOAD) begin
      gmem[q_head.gaddr] <= q_head.data;
    end
  end

  always_ff @(posedge clk) begin
    gdata_r <= gmem[gaddr_rd];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      line_r  <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (q_pop) begin
      base_r <= SLINE_W'(SLINE_W'(q_head.row) * SLINE_W'(CELL_LINES));
    end
  end

  always_comb begin
    code  = cur_r.data[CHAR_W-1:0];
    ch    = (code < CHAR_SPACE) ? CHAR_SPACE : code;
    gidx  = {code - CHAR_SPACE, line_r[2:0]};
    blank = (line_r >= LINE_W'(GLYPH_LINES)) || (code < CHAR_SPACE) ||
            ({1'b0, gidx} >= (GIDX_W + 1)'(FONT_SET_BYTES));
    cursor_line = cur_r.data[DATA_W-1] &&
                  (line_r == CURSOR_LINE_A || line_r == CURSOR_LINE_B);
    px = blank ? '0 : gdata_r;
    if (cursor_line) begin
      px = px ^ BYTE_ALL_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_read || load_line) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_read) begin
      read_data_r  <= q_head.data;
      is_render_r  <= 1'b0;
      pixel_r      <= '0;
      sline_r      <= '0;
      col_r        <= '0;
      text_valid_r <= 1'b0;
      char_r       <= '0;
      last_r       <= 1'b1;
    end else if (load_line) begin
      read_data_r  <= '0;
      is_render_r  <= 1'b1;
      pixel_r      <= px;
      sline_r      <= base_r + SLINE_W'(line_r);
      col_r        <= cur_r.col;
      text_valid_r <= console_mode && (line_r == '0);
      char_r       <= (console_mode && (line_r == '0)) ? ch : '0;
      last_r       <= (line_r == LAST_LINE);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = read_data_r;
  assign out_is_render   = is_render_r;
  assign out_pixel_bits  = pixel_r;
  assign out_screen_line = sline_r;
  assign out_cell_column = col_r;
  assign out_text_valid  = text_valid_r;
  assign out_text_char   = char_r;
  assign out_last        = last_r;

endmodule

// ===== sv/text_cell_vram_renderer_top.sv =====
`timescale 1ns / 1ps
// Text-cell video memory with a character generator, mapped onto a bus window.
// Input channel (in_*): one beat is a bus read, a bus write or a font byte load.
// Output channel (out_*): a read gives one reply beat; a write to a visible cell
// gives one beat per scan line of the cell, the final one flagged by out_last.
// Loads and writes outside the window or past the visible area give no beats.
// Configuration (cfg_*): written with cfg_write_en; the user must write it only
// while the block is idle, which the block itself does not enforce.
// A read reply passes the front-end capture registers, the queue and the output
// register; a visible write also passes the row register and the glyph store read,
// then the single glyph store read port gives one row per cycle while the receiver
// is ready. The front end takes no new item until it has pushed the current one.
// After reset the video memory is filled with 0xFF, one byte per cycle, while
// in_ready stays low until the whole window is filled.
// When the receiver stalls, the output register holds its beat, the two-entry
// queue fills and then the front end stops accepting input.
module text_cell_vram_renderer_top import tcvr_pkg::*; #(
  parameter int WINDOW_BYTES   = 2048,
  parameter int TEXT_COLUMNS   = 80,
  parameter int TEXT_ROWS      = 24,
  parameter int CELL_LINES     = 12,
  parameter int FONT_SET_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_read_data,
  output logic                 out_is_render,
  output logic [DATA_W-1:0]    out_pixel_bits,
  output logic [SLINE_W-1:0]   out_screen_line,
  output logic [COL_W-1:0]     out_cell_column,
  output logic                 out_text_valid,
  output logic [CHAR_W-1:0]    out_text_char,
  output logic                 out_last
);

  logic [DATA_W-1:0] base_high_r;
  logic              alt_font_r;
  logic              console_r;

  logic  push, q_full, q_pop, q_empty;
  qent_t push_ent, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_high_r <= BASE_RESET;
      alt_font_r  <= 1'b0;
      console_r   <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_WINDOW_BASE_HIGH: base_high_r <= cfg_write_data;
        CFG_ALTERNATE_FONT:   alt_font_r  <= cfg_write_data[0];
        CFG_CONSOLE_MODE:     console_r   <= cfg_write_data[0];
        default: ;
      endcase
    end
  end

  tcvr_front #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .base_high     (base_high_r),
    .push          (push),
    .push_ent      (push_ent),
    .q_full        (q_full)
  );

  tcvr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tcvr_back #(
    .CELL_LINES     (CELL_LINES),
    .FONT_SET_BYTES (FONT_SET_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .alt_font        (alt_font_r),
    .console_mode    (console_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_read_data   (out_read_data),
    .out_is_render   (out_is_render),
    .out_pixel_bits  (out_pixel_bits),
    .out_screen_line (out_screen_line),
    .out_cell_column (out_cell_column),
    .out_text_valid  (out_text_valid),
    .out_text_char   (out_text_char),
    .out_last        (out_last)
  );

endmodule

// ===== tb/tcvr_beat_checker.sv =====
`timescale 1ns / 1ps
module tcvr_beat_checker import tcvr_pkg::*; #(
  parameter int WINDOW_BYTES   = 2048,
  parameter int TEXT_COLUMNS   = 80,
  parameter int TEXT_ROWS      = 24,
  parameter int CELL_LINES     = 12,
  parameter int FONT_SET_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_write_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DATA_W-1:0]    out_read_data,
  input  logic                 out_is_render,
  input  logic [DATA_W-1:0]    out_pixel_bits,
  input  logic [SLINE_W-1:0]   out_screen_line,
  input  logic [COL_W-1:0]     out_cell_column,
  input  logic                 out_text_valid,
  input  logic [CHAR_W-1:0]    out_text_char,
  input  logic                 out_last,
  output int                   beats_awaited,
  output int                   mismatches
);

  localparam int AW         = $clog2(WINDOW_BYTES);
  localparam int BEAT_SLOTS = 1024;
  localparam int SLOT_W     = $clog2(BEAT_SLOTS);

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               is_render;
    logic [DATA_W-1:0]  pixel_bits;
    logic [SLINE_W-1:0] screen_line;
    logic [COL_W-1:0]   cell_column;
    logic               text_valid;
    logic [CHAR_W-1:0]  text_char;
    logic               last;
  } cell_beat_t;

  logic [DATA_W-1:0] vram_shadow [WINDOW_BYTES];
  logic [DATA_W-1:0] font_shadow [2**GLYPH_AW];
  logic [DATA_W-1:0] base_high;
  logic              font_set;
  logic              console_on;
  cell_beat_t        awaited_beats [BEAT_SLOTS];
  logic [SLOT_W-1:0] put_ptr = '0;
  logic [SLOT_W-1:0] take_ptr = '0;
  int                pending = 0;
  int                fail_total = 0;

  assign mismatches = fail_total;

  function automatic logic [DATA_W-1:0] glyph_row(input logic [CHAR_W-1:0] code, input int line);
    int                idx;
    logic [GIDX_W-1:0] gidx;
    if (line >= GLYPH_LINES || code < CHAR_SPACE) return '0;
    idx = (int'(code) - int'(CHAR_SPACE)) * GLYPH_LINES + line;
    if (idx >= FONT_SET_BYTES) return '0;
    gidx = idx[GIDX_W-1:0];
    return font_shadow[{font_set, gidx}];
  endfunction

  task automatic queue_beat(input cell_beat_t beat);
    awaited_beats[put_ptr] = beat;
    put_ptr = put_ptr + 1'b1;
    pending++;
  endtask

  task automatic predict_bus_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] data);
    logic [ADDR_W-1:0] offset;
    logic [CHAR_W-1:0] code;
    cell_beat_t        beat;
    int                col;
    int                row;
    offset = addr - {base_high, 8'h00};
    code = data[CHAR_W-1:0];
    beat = '0;
    case (op)
      OP_READ: begin
        beat.read_data = (offset < WINDOW_BYTES) ? vram_shadow[offset[AW-1:0]]
                                                 : BYTE_ALL_ONES;
        beat.last = 1'b1;
        queue_beat(beat);
      end
      OP_LOAD: begin
        font_shadow[addr[GLYPH_AW-1:0]] = data;
      end
      OP_WRITE: begin
        if (offset < WINDOW_BYTES) begin
          vram_shadow[offset[AW-1:0]] = data;
          if (offset < TEXT_COLUMNS * TEXT_ROWS) begin
            col = offset % TEXT_COLUMNS;
            row = offset / TEXT_COLUMNS;
            for (int line = 0; line < CELL_LINES; line++) begin
              beat = '0;
              beat.is_render = 1'b1;
              beat.pixel_bits = glyph_row(code, line);
              if (data[DATA_W-1] && (line == CURSOR_LINE_A || line == CURSOR_LINE_B)) begin
                beat.pixel_bits = ~beat.pixel_bits;
              end
              beat.screen_line = SLINE_W'(row * CELL_LINES + line);
              beat.cell_column = COL_W'(col);
              beat.text_valid = (line == 0) && console_on;
              if (beat.text_valid) beat.text_char = (code < CHAR_SPACE) ? CHAR_SPACE : code;
              beat.last = (line == CELL_LINES - 1);
              queue_beat(beat);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    cell_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_BYTES; i++) vram_shadow[i] = BYTE_ALL_ONES;
      base_high = BASE_RESET;
      font_set = 1'b0;
      console_on = 1'b0;
      put_ptr = '0;
      take_ptr = '0;
      pending = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending == 0) begin
          $error("result beat arrived with no expectation pending");
          fail_total++;
        end else begin
          want = awaited_beats[take_ptr];
          take_ptr = take_ptr + 1'b1;
          pending--;
          compare_field("read_data", 16'(want.read_data), 16'(out_read_data));
          compare_field("is_render", 16'(want.is_render), 16'(out_is_render));
          compare_field("pixel_bits", 16'(want.pixel_bits), 16'(out_pixel_bits));
          compare_field("screen_line", 16'(want.screen_line), 16'(out_screen_line));
          compare_field("cell_column", 16'(want.cell_column), 16'(out_cell_column));
          compare_field("text_valid", 16'(want.text_valid), 16'(out_text_valid));
          compare_field("text_char", 16'(want.text_char), 16'(out_text_char));
          compare_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_WINDOW_BASE_HIGH: base_high = cfg_write_data;
          CFG_ALTERNATE_FONT:   font_set = cfg_write_data[0];
          CFG_CONSOLE_MODE:     console_on = cfg_write_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_bus_item(in_opcode, in_address, in_write_data);
    end
    beats_awaited <= pending;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import tcvr_pkg::*;

  localparam int WINDOW_BYTES   = 2048;
  localparam int TEXT_COLUMNS   = 80;
  localparam int TEXT_ROWS      = 24;
  localparam int CELL_LINES     = 12;
  localparam int FONT_SET_BYTES = 1024;
  localparam int VISIBLE_CELLS  = TEXT_COLUMNS * TEXT_ROWS;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int CYCLE_LIMIT    = 1_500_000;

  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [ADDR_W-1:0]    in_address = '0;
  logic [DATA_W-1:0]    in_write_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DATA_W-1:0]    out_read_data;
  logic                 out_is_render;
  logic [DATA_W-1:0]    out_pixel_bits;
  logic [SLINE_W-1:0]   out_screen_line;
  logic [COL_W-1:0]     out_cell_column;
  logic                 out_text_valid;
  logic [CHAR_W-1:0]    out_text_char;
  logic                 out_last;
  int                   beats_awaited;
  int                   mismatches;

  logic [DATA_W-1:0] base_shadow = BASE_RESET;
  logic              font_sel = 1'b0;
  bit                glyph_ready [2**GLYPH_AW];
  bit                no_gaps = 1'b0;
  int                items_sent = 0;
  int                hold_token = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                rx_wait = 0;
  int                cycles_run = 0;

  always #5 clk = ~clk;

  text_cell_vram_renderer_top #(
    .WINDOW_BYTES(WINDOW_BYTES), .TEXT_COLUMNS(TEXT_COLUMNS), .TEXT_ROWS(TEXT_ROWS),
    .CELL_LINES(CELL_LINES), .FONT_SET_BYTES(FONT_SET_BYTES)
  ) uut (.*);

  tcvr_beat_checker #(
    .WINDOW_BYTES(WINDOW_BYTES), .TEXT_COLUMNS(TEXT_COLUMNS), .TEXT_ROWS(TEXT_ROWS),
    .CELL_LINES(CELL_LINES), .FONT_SET_BYTES(FONT_SET_BYTES)
  ) beat_check (.*);

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // The receiver stalls at random after each beat, or for one long stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_wait == 0 && out_valid && out_ready) rx_wait = pick_gap();
      else if (rx_wait > 0) rx_wait = rx_wait - 1;
      out_ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycles_run, beats_awaited);
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] cell_address(input logic [ADDR_W-1:0] offset);
    return {base_shadow, 8'h00} + offset;
  endfunction

  function automatic logic [GLYPH_AW-1:0] glyph_index(input logic [CHAR_W-1:0] code,
                                                       input int line);
    logic [GIDX_W-1:0] idx;
    idx = GIDX_W'((int'(code) - int'(CHAR_SPACE)) * GLYPH_LINES + line);
    return {font_sel, idx};
  endfunction

  function automatic bit glyph_loaded(input logic [CHAR_W-1:0] code);
    for (int line = 0; line < GLYPH_LINES; line++) begin
      if (!glyph_ready[glyph_index(code, line)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_address <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (beats_awaited != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] alt_val,
                          input logic [DATA_W-1:0] console_val);
    wait_idle();
    write_reg(CFG_WINDOW_BASE_HIGH, base);
    write_reg(CFG_ALTERNATE_FONT, alt_val);
    write_reg(CFG_CONSOLE_MODE, console_val);
    base_shadow = base;
    font_sel = alt_val[0];
  endtask

  task automatic load_glyph(input logic [CHAR_W-1:0] code, input logic [4:0] upper);
    logic [GLYPH_AW-1:0] gaddr;
    for (int line = 0; line < GLYPH_LINES; line++) begin
      gaddr = glyph_index(code, line);
      send_beat(OP_LOAD, {upper, gaddr}, DATA_W'($urandom_range(0, 255)));
      glyph_ready[gaddr] = 1'b1;
    end
  endtask

  // A visible cell with a printable code is only written once its glyph rows are in the font store.
  task automatic write_cell(input logic [ADDR_W-1:0] offset, input logic [DATA_W-1:0] data);
    if (offset < VISIBLE_CELLS && data[CHAR_W-1:0] >= CHAR_SPACE
        && !glyph_loaded(data[CHAR_W-1:0])) begin
      load_glyph(data[CHAR_W-1:0], 5'($urandom_range(0, 31)));
    end
    send_beat(OP_WRITE, cell_address(offset), data);
  endtask

  task automatic random_item();
    int                r;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    r = $urandom_range(0, 99);
    addr = ADDR_W'($urandom_range(0, 65535));
    data = DATA_W'($urandom_range(0, 255));
    if (r < 45) begin
      write_cell(ADDR_W'($urandom_range(0, VISIBLE_CELLS - 1)), data);
    end else if (r < 60) begin
      send_beat(OP_READ, cell_address(ADDR_W'($urandom_range(0, WINDOW_BYTES - 1))), data);
    end else if (r < 68) begin
      send_beat(OP_READ, addr, data);
    end else if (r < 76) begin
      write_cell(ADDR_W'($urandom_range(VISIBLE_CELLS, WINDOW_BYTES - 1)), data);
    end else if (r < 82) begin
      write_cell(addr, data);
    end else if (r < 92) begin
      send_beat(OP_LOAD, addr, data);
      glyph_ready[addr[GLYPH_AW-1:0]] = 1'b1;
    end else if (r < 96) begin
      send_beat(OP_UNUSED, addr, data);
    end else begin
      addr = ADDR_W'($urandom_range(0, WINDOW_BYTES - 1));
      write_cell(addr, data);
      send_beat(OP_READ, cell_address(addr), ~data);
    end
  endtask

  task automatic run_items(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) random_item();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    set_regs(BASE_RESET, 8'h00, 8'h01);

    send_beat(OP_READ, cell_address(0), 8'h00);
    send_beat(OP_READ, cell_address('1), 8'hFF);
    send_beat(OP_READ, cell_address(WINDOW_BYTES - 1), 8'h00);
    load_glyph(7'h41, 5'h1F);
    send_beat(OP_LOAD, 16'h03FF, 8'hA5);
    glyph_ready[11'h3FF] = 1'b1;
    write_cell(0, 8'h41);
    write_cell(VISIBLE_CELLS - 1, 8'hC1);
    write_cell(TEXT_COLUMNS - 1, 8'h00);
    write_cell(TEXT_COLUMNS, 8'h9F);
    write_cell(1, 8'h80);
    write_cell(VISIBLE_CELLS, 8'h7F);
    write_cell(WINDOW_BYTES - 1, 8'h55);
    write_cell(WINDOW_BYTES, 8'h12);
    send_beat(OP_UNUSED, 16'hFFFF, 8'hFF);
    send_beat(OP_READ, cell_address(VISIBLE_CELLS), 8'h00);
    send_beat(OP_READ, cell_address(WINDOW_BYTES - 1), 8'h00);
    send_beat(OP_READ, cell_address(0), 8'h00);

    // The window wraps past the top of the bus address space here.
    set_regs(8'hFF, 8'h01, 8'hFE);
    write_reg(CFG_UNUSED, DATA_W'($urandom_range(0, 255)));
    run_items(110);

    // Fill the block while the receiver holds off, then let it drain completely.
    // Control codes with random cursor bits keep font loads out of this stretch.
    hold_token <= hold_token + 1;
    no_gaps <= 1'b1;
    repeat (40) write_cell(ADDR_W'($urandom_range(0, VISIBLE_CELLS - 1)),
                           DATA_W'($urandom_range(0, 255)) & 8'h9F);
    no_gaps <= 1'b0;

    set_regs(8'h00, 8'hFE, 8'h03);
    no_gaps <= 1'b1;
    run_items(60);
    no_gaps <= 1'b0;

    set_regs(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)),
             DATA_W'($urandom_range(0, 255)));
    run_items(100);

    set_regs(BASE_RESET, 8'h01, 8'h01);
    run_items(90);

    wait_idle();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
